>>> sv/csp_pkg.sv
// Shared types, constants and helpers for the CAN signal pack/unpack block.
package csp_pkg;

    // Payload geometry
    localparam int unsigned PAYLOAD_BYTES = 8;
    localparam int unsigned PAYLOAD_BITS  = 8 * PAYLOAD_BYTES;
    localparam int unsigned W_FRAME       = 64;
    localparam int unsigned W_START       = 6;
    localparam int unsigned W_LEN         = 7;

    // Operation codes
    typedef enum logic {
        KIND_EXTRACT = 1'b0,
        KIND_INSERT  = 1'b1
    } t_kind;

    // One accepted command, as held in the input register
    typedef struct packed {
        t_kind                kind;
        logic [W_FRAME-1:0]   frame_data;
        logic [W_START-1:0]   sig_start;
        logic [W_LEN-1:0]     sig_len;
        logic                 big_endian;
        logic                 is_signed;
        logic [W_FRAME-1:0]   value_in;
    } t_item;

    // Signal geometry and clipped insert value, passed to the field stage
    typedef struct packed {
        t_kind                kind;
        logic                 big_endian;
        logic                 sign_ext;
        logic                 range_error;
        logic                 saturated;
        logic [W_FRAME-1:0]   frame;
        logic [W_FRAME-1:0]   word;
        logic [W_FRAME-1:0]   mask;
        logic [W_FRAME-1:0]   ins_raw;
        logic [W_START-1:0]   shift;
    } t_stage;

    // Reverse the byte order of a 64-bit word
    function automatic logic [W_FRAME-1:0] swap_bytes(input logic [W_FRAME-1:0] x);
        logic [W_FRAME-1:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            r[8*k +: 8] = x[8*(7-k) +: 8];
        end
        return r;
    endfunction

endpackage

>>> sv/csp_geom.sv
// Geometry stage: stream position, range check, mask, shift and insert saturation.
module csp_geom #(
    parameter int unsigned P_PAYLOAD_BYTES = csp_pkg::PAYLOAD_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  csp_pkg::t_item  i_item,
    output logic            o_valid,
    output csp_pkg::t_stage o_stage
);
    import csp_pkg::*;

    logic [W_START-1:0] pos;
    logic [7:0]         span;
    logic [W_START-1:0] mask_gap;
    logic [W_START-1:0] mot_shift;
    logic               rerr;
    logic [W_FRAME-1:0] mask;
    logic [W_FRAME-1:0] hi;
    logic [W_FRAME-1:0] lo;
    logic [W_FRAME-1:0] raw;
    logic               clip;
    t_stage             n_stage;
    logic               r_valid;
    t_stage             r_stage;

    // Locate the first stream bit; Motorola numbering runs MSB-first in each byte
    always_comb begin
        pos = i_item.big_endian ? {i_item.sig_start[5:3], ~i_item.sig_start[2:0]}
                                : i_item.sig_start;
        span      = {2'b00, pos} + {1'b0, i_item.sig_len};
        rerr      = (i_item.sig_len == '0) || (i_item.sig_len > W_LEN'(64))
                    || (span > 8'(8 * P_PAYLOAD_BYTES));
        mask_gap  = W_START'(W_LEN'(64) - i_item.sig_len);
        mask      = {W_FRAME{1'b1}} >> mask_gap;
        mot_shift = W_START'(8'd64 - span);
    end

    // Clip the insert value to the signal's range
    always_comb begin
        hi   = mask >> 1;
        lo   = ~hi;
        raw  = i_item.value_in;
        clip = 1'b0;
        if (i_item.is_signed) begin
            if ($signed(i_item.value_in) < $signed(lo)) begin
                raw  = lo;
                clip = 1'b1;
            end else if ($signed(i_item.value_in) > $signed(hi)) begin
                raw  = hi;
                clip = 1'b1;
            end
        end else begin
            if (i_item.value_in[W_FRAME-1]) begin
                raw  = '0;
                clip = 1'b1;
            end else if (i_item.value_in > mask) begin
                raw  = mask;
                clip = 1'b1;
            end
        end
    end

    // Assemble the stage word
    always_comb begin
        n_stage.kind        = i_item.kind;
        n_stage.big_endian  = i_item.big_endian;
        n_stage.sign_ext    = i_item.is_signed;
        n_stage.range_error = rerr;
        n_stage.saturated   = clip && !rerr && (i_item.kind == KIND_INSERT);
        n_stage.frame       = i_item.frame_data;
        n_stage.word        = i_item.big_endian ? swap_bytes(i_item.frame_data)
                                                : i_item.frame_data;
        n_stage.mask        = mask;
        n_stage.ins_raw     = raw & mask;
        n_stage.shift       = i_item.big_endian ? mot_shift : pos;
    end

    // Hold the stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_stage <= n_stage;
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

>>> sv/csp_field.sv
// Field stage: extract with sign extension or insert into the payload, result register.
module csp_field (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  csp_pkg::t_stage             i_stage,
    output logic                        o_done,
    output logic [csp_pkg::W_FRAME-1:0] o_frame_out,
    output logic [csp_pkg::W_FRAME-1:0] o_value_out,
    output logic                        o_saturated,
    output logic                        o_range_error
);
    import csp_pkg::*;

    logic [W_FRAME-1:0] field;
    logic               field_msb;
    logic [W_FRAME-1:0] ext;
    logic [W_FRAME-1:0] ins_word;
    logic [W_FRAME-1:0] n_frame;
    logic [W_FRAME-1:0] n_value;
    logic               r_done;
    logic [W_FRAME-1:0] r_frame;
    logic [W_FRAME-1:0] r_value;
    logic               r_sat;
    logic               r_rerr;

    // Extract the field and sign-extend signed fields from their top bit
    always_comb begin
        field     = (i_stage.word >> i_stage.shift) & i_stage.mask;
        field_msb = |(field & (i_stage.mask ^ (i_stage.mask >> 1)));
        ext       = (i_stage.sign_ext && field_msb) ? (field | ~i_stage.mask) : field;
    end

    // Overwrite the field bits and restore byte order
    always_comb begin
        ins_word = (i_stage.word & ~(i_stage.mask << i_stage.shift))
                   | (i_stage.ins_raw << i_stage.shift);
        n_frame  = i_stage.frame;
        n_value  = '0;
        if (!i_stage.range_error) begin
            unique case (i_stage.kind)
                KIND_EXTRACT: n_value = ext;
                KIND_INSERT:  n_frame = i_stage.big_endian ? swap_bytes(ins_word) : ins_word;
                default:      n_value = '0;
            endcase
        end
    end

    // Hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
        r_frame <= n_frame;
        r_value <= n_value;
        r_sat   <= i_stage.saturated;
        r_rerr  <= i_stage.range_error;
    end

    assign o_done        = r_done;
    assign o_frame_out   = r_frame;
    assign o_value_out   = r_value;
    assign o_saturated   = r_sat;
    assign o_range_error = r_rerr;

endmodule

>>> sv/can_signal_pack_unpack.sv
// Top level of the CAN signal pack/unpack block: input register and the two stages.
//
//  Channel   Handshake                  Payload
//  command   start (busy low)           i_kind, i_frame_data, i_sig_start, i_sig_len,
//                                       i_big_endian, i_is_signed, i_value_in
//  result    o_done (one-cycle strobe)  o_frame_out, o_value_out, o_saturated,
//                                       o_range_error
//
//  One command per cycle; busy stays low. A transfer taken at one edge passes the input
//  register, the geometry/saturation register and the result register, which drives
//  o_done and the result outputs.
//  Synchronous active-low reset clears the valid bits of all three registers.
//  The receiver cannot stall: each result is shown for one cycle only.
module can_signal_pack_unpack #(
    parameter int unsigned P_PAYLOAD_BYTES = csp_pkg::PAYLOAD_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_kind,
    input  logic [csp_pkg::W_FRAME-1:0] i_frame_data,
    input  logic [csp_pkg::W_START-1:0] i_sig_start,
    input  logic [csp_pkg::W_LEN-1:0]   i_sig_len,
    input  logic                        i_big_endian,
    input  logic                        i_is_signed,
    input  logic [csp_pkg::W_FRAME-1:0] i_value_in,
    output logic                        o_done,
    output logic [csp_pkg::W_FRAME-1:0] o_frame_out,
    output logic [csp_pkg::W_FRAME-1:0] o_value_out,
    output logic                        o_saturated,
    output logic                        o_range_error
);
    import csp_pkg::*;

    logic   r_in_valid;
    t_item  r_item;
    t_item  n_item;
    logic   geom_valid;
    t_stage geom_stage;

    // Every cycle is free for a new transfer
    assign busy = 1'b0;

    always_comb begin
        n_item.kind       = t_kind'(i_kind);
        n_item.frame_data = i_frame_data;
        n_item.sig_start  = i_sig_start;
        n_item.sig_len    = i_sig_len;
        n_item.big_endian = i_big_endian;
        n_item.is_signed  = i_is_signed;
        n_item.value_in   = i_value_in;
    end

    // Capture the command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        r_item <= n_item;
    end

    csp_geom #(
        .P_PAYLOAD_BYTES (P_PAYLOAD_BYTES)
    ) u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_item),
        .o_valid (geom_valid),
        .o_stage (geom_stage)
    );

    csp_field u_field (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (geom_valid),
        .i_stage       (geom_stage),
        .o_done        (o_done),
        .o_frame_out   (o_frame_out),
        .o_value_out   (o_value_out),
        .o_saturated   (o_saturated),
        .o_range_error (o_range_error)
    );

endmodule
